[rtl/tlw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlw_pkg
// Shared widths, codes and types of the lineage walk unit.
// ----------------------------------------------------------------------------
package tlw_pkg;

  localparam int ID_W   = 20;
  localparam int RANK_W = 3;

  localparam int NODE_COUNT_DEF = 1048576;
  localparam int RANK_COUNT_DEF = 6;
  localparam int MAX_HOPS_DEF   = 64;

  localparam logic [ID_W-1:0]   ROOT_ID = ID_W'(1);
  localparam logic [RANK_W-1:0] NO_RANK = RANK_W'(6);

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 5;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } tlw_op_t;

  // one node table entry
  typedef struct packed {
    logic [ID_W-1:0]   parent;
    logic [RANK_W-1:0] rank;
  } tlw_entry_t;

  // access strobes from the walker to the node table
  typedef struct packed {
    logic we;
    logic re;
  } tlw_tbl_ctl_t;

endpackage

[rtl/tlw_node_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlw_node_table
// Single-port node table with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module tlw_node_table
  import tlw_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  localparam int ADDR_W    = $clog2(NODE_COUNT)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tlw_tbl_ctl_t      ctl,
  input  logic [ADDR_W-1:0] addr,
  input  tlw_entry_t        wdata,
  output tlw_entry_t        rdata,
  output logic              clr_busy
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NODE_COUNT - 1);

  tlw_entry_t        mem [NODE_COUNT];
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  tlw_entry_t        wval;

  assign clr_busy = clr_busy_r;

  // sweep owns the write port until every entry holds its reset value
  always_comb begin
    if (clr_busy_r) begin
      we    = 1'b1;
      waddr = clr_addr_r;
      wval  = '{parent: '0, rank: NO_RANK};
    end else begin
      we    = ctl.we;
      waddr = addr;
      wval  = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wval;
    end
    if (ctl.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/taxonomy_lineage_walk_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taxonomy_lineage_walk_unit
// Node table of parent links and rank codes; lineage query by link walking.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------------
//  in_     | in  | tuser: opcode; tdata: node_id, parent_id, rank_code
//  out_    | out | tuser: rank_slot, known, truncated; tdata: ancestor_id;
//          |     | tlast on the final rank of a query
//
//  A write beat is taken and the input stays open. A query walks the parent
//  links one node at a time (one table read per in-range node, the stopping
//  node included, MAX_HOPS nodes at most), then sends one beat per rank,
//  RANK_COUNT beats in all; a start id of zero skips the walk. After reset a
//  sweep writes every table entry while in_tready stays low. out_tready low
//  holds the current result beat; the input side stays closed until the last
//  result beat of a query has left.
//
module taxonomy_lineage_walk_unit
  import tlw_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int RANK_COUNT = RANK_COUNT_DEF,
  parameter int MAX_HOPS   = MAX_HOPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [19:0] node_id, [39:20] parent_id, [42:40] rank_code, [47:43] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] opcode
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [19:0] ancestor_id, [23:20] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [2:0] rank_slot, [3] known, [4] truncated
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tlast
);

  localparam int ADDR_W = $clog2(NODE_COUNT);
  localparam int EXT_W  = (ADDR_W > ID_W) ? ADDR_W : ID_W;
  localparam int HOP_W  = $clog2(MAX_HOPS + 1);
  localparam int SLOT_W = (RANK_COUNT > 1) ? $clog2(RANK_COUNT) : 1;

  localparam logic [EXT_W:0]    NODE_LIM  = (EXT_W + 1)'(NODE_COUNT);
  localparam logic [HOP_W-1:0]  HOP_LIM   = HOP_W'(MAX_HOPS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RANK_COUNT - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_WALK  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  // node_id inside the table range
  function automatic logic id_in_range(input logic [ID_W-1:0] id);
    return {{(EXT_W + 1 - ID_W){1'b0}}, id} < NODE_LIM;
  endfunction

  state_t            state_r,  state_nxt;
  logic [ID_W-1:0]   cur_r,    cur_nxt;
  logic [HOP_W-1:0]  hops_r,   hops_nxt;
  logic              rng_r,    rng_nxt;
  logic              trunc_r,  trunc_nxt;
  logic [SLOT_W-1:0] slot_r,   slot_nxt;
  logic [RANK_COUNT-1:0] found_vld_r, found_vld_nxt;
  logic [ID_W-1:0]   found_id_r  [RANK_COUNT];
  logic [ID_W-1:0]   found_id_nxt [RANK_COUNT];

  tlw_op_t           in_opcode;
  logic [ID_W-1:0]   in_node_id;
  logic [ID_W-1:0]   in_parent_id;
  logic [RANK_W-1:0] in_rank_code;
  logic              in_acc;
  logic              in_node_rng;

  tlw_tbl_ctl_t      tbl_ctl;
  logic [ADDR_W-1:0] tbl_addr;
  tlw_entry_t        tbl_wdata;
  tlw_entry_t        tbl_rdata;
  logic              clr_busy;

  logic [ID_W-1:0]   walk_par;
  logic [RANK_W-1:0] walk_rank;
  logic              par_rng;
  logic [HOP_W-1:0]  hop_inc;
  logic              out_acc;

  // unpack the input beat
  assign in_opcode    = tlw_op_t'(in_tuser);
  assign in_node_id   = in_tdata[19:0];
  assign in_parent_id = in_tdata[39:20];
  assign in_rank_code = in_tdata[42:40];
  assign in_acc       = in_tvalid && in_tready;
  assign in_node_rng  = id_in_range(in_node_id);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_EMIT);
  assign out_acc    = out_tvalid && out_tready;

  // an id beyond the table reads as no parent and no rank
  assign walk_par  = rng_r ? tbl_rdata.parent : '0;
  assign walk_rank = rng_r ? tbl_rdata.rank   : NO_RANK;
  assign par_rng   = id_in_range(walk_par);
  assign hop_inc   = hops_r + HOP_W'(1);

  tlw_node_table #(
    .NODE_COUNT (NODE_COUNT)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (tbl_ctl),
    .addr     (tbl_addr),
    .wdata    (tbl_wdata),
    .rdata    (tbl_rdata),
    .clr_busy (clr_busy)
  );

  assign tbl_wdata = '{parent: in_parent_id, rank: in_rank_code};

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    hops_nxt      = hops_r;
    rng_nxt       = rng_r;
    trunc_nxt     = trunc_r;
    slot_nxt      = slot_r;
    found_vld_nxt = found_vld_r;
    found_id_nxt  = found_id_r;
    tbl_ctl       = '0;
    tbl_addr      = ADDR_W'(in_node_id);

    unique case (state_r)
      S_CLEAR: begin
        // hold the input closed until the sweep is through
        if (!clr_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_WRITE) begin
            // drop writes beyond the table
            tbl_ctl.we = in_node_rng;
          end else begin
            found_vld_nxt = '0;
            trunc_nxt     = 1'b0;
            cur_nxt       = in_node_id;
            hops_nxt      = '0;
            slot_nxt      = '0;
            if (in_node_id == '0) begin
              state_nxt = S_EMIT;
            end else begin
              tbl_ctl.re = in_node_rng;
              rng_nxt    = in_node_rng;
              state_nxt  = S_WALK;
            end
          end
        end
      end
      S_WALK: begin
        // entry of cur_r is on the read port this cycle
        if (cur_r == ROOT_ID || walk_par == ROOT_ID) begin
          state_nxt = S_EMIT;
        end else begin
          // record the first node met at each rank
          for (int k = 0; k < RANK_COUNT; k++) begin
            if (walk_rank == RANK_W'(k) && !found_vld_r[k]) begin
              found_vld_nxt[k] = 1'b1;
              found_id_nxt[k]  = cur_r;
            end
          end
          cur_nxt  = walk_par;
          hops_nxt = hop_inc;
          if (hop_inc == HOP_LIM) begin
            trunc_nxt = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            // advance: read the parent next
            tbl_ctl.re = par_rng;
            tbl_addr   = ADDR_W'(walk_par);
            rng_nxt    = par_rng;
          end
        end
      end
      S_EMIT: begin
        if (out_acc) begin
          if (slot_r == LAST_SLOT) begin
            state_nxt = S_IDLE;
          end else begin
            slot_nxt = slot_r + SLOT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      found_vld_r <= '0;
      trunc_r     <= 1'b0;
      slot_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      found_vld_r <= found_vld_nxt;
      trunc_r     <= trunc_nxt;
      slot_r      <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    hops_r     <= hops_nxt;
    rng_r      <= rng_nxt;
    found_id_r <= found_id_nxt;
  end

  // result beat: unknown ranks show id zero
  assign out_tdata = {{(OUT_TDATA_W - ID_W){1'b0}},
                      found_vld_r[slot_r] ? found_id_r[slot_r] : {ID_W{1'b0}}};
  assign out_tuser = {trunc_r, found_vld_r[slot_r], RANK_W'(slot_r)};
  assign out_tlast = (slot_r == LAST_SLOT);

endmodule

[rtl/tlw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlw_checker
// Port-level checks on the result stream of the lineage walk unit.
// ----------------------------------------------------------------------------
module tlw_checker
  import tlw_pkg::*;
#(
  parameter int RANK_COUNT = RANK_COUNT_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser,
  input logic                   out_tlast
);

  localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(RANK_COUNT - 1);

  // no new item is taken while a query still delivers results
  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input open while results pending");

  // the final beat reports the top rank
  a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tuser[2:0] == LAST_RANK))
    else $error("tlast on wrong rank slot");

  // unknown ranks carry id zero
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[3]) |-> (out_tdata == '0))
    else $error("unknown rank with nonzero id");

  // ranks follow in order, truncation flag constant over a query
  a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && (out_tuser[2:0] == $past(out_tuser[2:0]) + 3'd1) &&
       (out_tuser[4] == $past(out_tuser[4]))))
    else $error("rank sequence broken");

  // the stream falls idle after the final beat
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("result beat after tlast");

endmodule

bind taxonomy_lineage_walk_unit tlw_checker #(
  .RANK_COUNT (RANK_COUNT)
) u_tlw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Lineage walk unit: node table writes and lineage queries.
// Beats are driven at the falling edge and sampled at the rising edge. A
// scoreboard object mirrors the node table, walks parent links itself for
// every query it sees accepted and compares each result beat with the
// oldest rank it predicted. Stimulus opens with hand-built lineages (root
// stops, cycles, unknown links, rank codes outside the six ranks) and goes
// on with random trees built over a pool of random ids, deep enough to
// reach the hop limit, mixed with broken links and stray queries.
// ----------------------------------------------------------------------------
module testbench;
  import tlw_pkg::*;

  localparam int POOL_SIZE  = 96;
  localparam int RAND_ITEMS = 320;

  // one predicted result beat
  typedef struct packed {
    logic [RANK_W-1:0] slot;
    logic [ID_W-1:0]   ancestor;
    logic              known;
    logic              trunc;
    logic              last;
  } rank_beat_t;

  // Mirror of the node table plus the queue of rank beats still owed.
  class lineage_board;
    logic [ID_W-1:0]   parent_tab [int unsigned];
    logic [RANK_W-1:0] rank_tab [int unsigned];
    rank_beat_t        pending_ranks [$];
    int errors;
    int writes;
    int queries;
    int beats_checked;
    int truncated_walks;

    function new();
      errors          = 0;
      writes          = 0;
      queries         = 0;
      beats_checked   = 0;
      truncated_walks = 0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("[%0t] error: %s", $time, what);
    endtask

    // Walk parent links from start and queue one beat per rank.
    function void walk_lineage(logic [ID_W-1:0] start);
      logic [ID_W-1:0]   hit [RANK_COUNT_DEF];
      bit                seen [RANK_COUNT_DEF];
      logic [ID_W-1:0]   cur;
      logic [ID_W-1:0]   par;
      logic [RANK_W-1:0] rk;
      bit                done;
      int                hops;
      rank_beat_t        beat;
      for (int k = 0; k < RANK_COUNT_DEF; k++) begin
        hit[k]  = '0;
        seen[k] = 1'b0;
      end
      done = 1'b0;
      cur  = start;
      hops = 0;
      if (start != '0) begin
        while (hops < MAX_HOPS_DEF && !done) begin
          par = parent_tab.exists(cur) ? parent_tab[cur] : '0;
          if (cur == ROOT_ID || par == ROOT_ID) begin
            done = 1'b1;
          end else begin
            rk = rank_tab.exists(cur) ? rank_tab[cur] : NO_RANK;
            if (rk < RANK_COUNT_DEF && !seen[rk]) begin
              seen[rk] = 1'b1;
              hit[rk]  = cur;
            end
            cur = par;
            hops++;
          end
        end
      end
      if (start != '0 && !done) truncated_walks++;
      for (int k = 0; k < RANK_COUNT_DEF; k++) begin
        beat.slot     = RANK_W'(k);
        beat.ancestor = seen[k] ? hit[k] : '0;
        beat.known    = seen[k];
        beat.trunc    = (start != '0) && !done;
        beat.last     = (k == RANK_COUNT_DEF - 1);
        pending_ranks = {pending_ranks, beat};
      end
    endfunction

    function void note_item(tlw_op_t op, logic [ID_W-1:0] node, logic [ID_W-1:0] parent,
                            logic [RANK_W-1:0] rk);
      if (op == OP_WRITE) begin
        writes++;
        parent_tab[node] = parent;
        rank_tab[node]   = rk;
      end else begin
        queries++;
        walk_lineage(node);
      end
    endfunction

    task check_rank_beat(logic [RANK_W-1:0] slot, logic [ID_W-1:0] anc, logic known,
                         logic trunc, logic last);
      rank_beat_t want;
      beats_checked++;
      if (pending_ranks.size() == 0) begin
        report($sformatf("result beat slot %0d id %05h with nothing pending", slot, anc));
        return;
      end
      want = pending_ranks.pop_front();
      if (slot !== want.slot)
        report($sformatf("rank_slot %0d, expected %0d", slot, want.slot));
      if (anc !== want.ancestor)
        report($sformatf("slot %0d ancestor_id %05h, expected %05h", want.slot, anc,
                         want.ancestor));
      if (known !== want.known)
        report($sformatf("slot %0d known %b, expected %b", want.slot, known, want.known));
      if (trunc !== want.trunc)
        report($sformatf("slot %0d truncated %b, expected %b", want.slot, trunc, want.trunc));
      if (last !== want.last)
        report($sformatf("slot %0d tlast %b, expected %b", want.slot, last, want.last));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // [19:0] node_id, [39:20] parent_id, [42:40] rank_code, [47:43] zero
  logic [IN_TDATA_W-1:0]  in_tdata;
  // [0] opcode
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // [19:0] ancestor_id, [23:20] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  // [2:0] rank_slot, [3] known, [4] truncated
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  lineage_board    board;
  logic [ID_W-1:0] pool [POOL_SIZE];
  bit              tx_gappy = 1'b1;
  bit              rx_gappy = 1'b1;

  taxonomy_lineage_walk_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Sample both channels at the rising edge; values seen here are those
  // from before the edge, so the order of processes does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        board.note_item(tlw_op_t'(in_tuser), in_tdata[19:0], in_tdata[39:20],
                        in_tdata[42:40]);
      if (out_tvalid && out_tready)
        board.check_rank_beat(out_tuser[2:0], out_tdata[19:0], out_tuser[3], out_tuser[4],
                              out_tlast);
    end
  end

  // Offer one beat after a random gap and hold it until it is taken.
  // Called and returning at a falling edge.
  task send_item(tlw_op_t op, logic [ID_W-1:0] node, logic [ID_W-1:0] parent,
                 logic [RANK_W-1:0] rk);
    int gap;
    if ($urandom_range(0, 23) == 0) tx_gappy = !tx_gappy;
    gap = tx_gappy ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, rk, parent, node};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task put_node(logic [ID_W-1:0] node, logic [ID_W-1:0] parent, logic [RANK_W-1:0] rk);
    send_item(OP_WRITE, node, parent, rk);
  endtask

  // parent and rank fields carry noise on a query
  task ask_lineage(logic [ID_W-1:0] node);
    send_item(OP_QUERY, node, ID_W'($urandom), RANK_W'($urandom));
  endtask

  // Hold the sender until every owed rank beat has been seen.
  task drain_results();
    in_tvalid <= 1'b0;
    while (board.pending_ranks.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic [RANK_W-1:0] draw_rank();
    return ($urandom_range(0, 9) < 8) ? RANK_W'($urandom_range(0, 5))
                                      : RANK_W'($urandom_range(6, 7));
  endfunction

  // Mostly link to one of the few pool entries before, so chains run deep;
  // now and then hang off the root, link anywhere in the pool or off into
  // unknown ids.
  function automatic logic [ID_W-1:0] draw_parent(int idx);
    int pick;
    int back;
    pick = $urandom_range(0, 99);
    back = (idx > 3) ? 3 : idx;
    if (idx == 0 || (pick >= 70 && pick < 82)) return ROOT_ID;
    if (pick < 70) return pool[idx - $urandom_range(1, back)];
    if (pick < 90) return pool[$urandom_range(0, POOL_SIZE - 1)];
    return ID_W'($urandom);
  endfunction

  // Result side: stall a random number of cycles before each beat, with
  // stretches of full rate in between.
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 23) == 0) rx_gappy = !rx_gappy;
      gap = rx_gappy ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Run limit: covers the table sweep after reset and a slow run many times.
  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int idx;
    int pick;
    int waited;
    in_tvalid = 1'b0;
    in_tuser  = 1'b0;
    in_tdata  = '0;
    rst_n     = 1'b0;
    board     = new();
    for (int k = 0; k < POOL_SIZE; k++) pool[k] = ID_W'($urandom);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Queries on an empty table first: start id zero, the
    // root itself, and an unknown id whose walk spins on node zero.
    ask_lineage('0);
    ask_lineage(ROOT_ID);
    ask_lineage(20'hFFFFF);
    // full lineage with a second genus, an out-of-range rank code and a
    // top node hanging off the root
    put_node(20'hFFFFF, 20'h00010, 3'd0);
    put_node(20'h00010, 20'h00020, 3'd1);
    put_node(20'h00020, 20'h00030, 3'd7);
    put_node(20'h00030, 20'h00040, 3'd2);
    put_node(20'h00040, 20'h00050, 3'd1);
    put_node(20'h00050, 20'h00060, 3'd3);
    put_node(20'h00060, 20'h00070, 3'd4);
    put_node(20'h00070, 20'h00080, 3'd5);
    put_node(20'h00080, ROOT_ID, 3'd0);
    ask_lineage(20'hFFFFF);
    ask_lineage(20'h00080);
    ask_lineage(20'h00040);
    // two-node cycle: walk runs out of hops
    put_node(20'h12345, 20'h54321, 3'd2);
    put_node(20'h54321, 20'h12345, 3'd3);
    ask_lineage(20'h12345);
    // hang node zero off the root so unknown ids now stop cleanly
    put_node('0, ROOT_ID, 3'd0);
    ask_lineage(20'hABCDE);
    ask_lineage('0);
    // all-ones parent field, and an overwrite that drops the order
    put_node(20'h2AAAA, 20'hFFFFF, NO_RANK);
    ask_lineage(20'h2AAAA);
    put_node(20'h00050, 20'h00060, NO_RANK);
    ask_lineage(20'hFFFFF);
    drain_results();

    // Random part: build the pool trees in order, then mix rewrites with
    // queries, mostly on pool ids and now and then on stray ids.
    for (int k = 0; k < POOL_SIZE; k++) put_node(pool[k], draw_parent(k), draw_rank());
    drain_results();
    for (int n = 0; n < RAND_ITEMS - POOL_SIZE; n++) begin
      pick = $urandom_range(0, 99);
      idx  = $urandom_range(0, POOL_SIZE - 1);
      if (pick < 55) begin
        put_node(pool[idx], draw_parent(idx), draw_rank());
      end else if (pick < 95) begin
        ask_lineage(pool[idx]);
      end else begin
        case ($urandom_range(0, 2))
          0:       ask_lineage('0);
          1:       ask_lineage(ROOT_ID);
          default: ask_lineage(ID_W'($urandom));
        endcase
      end
      if (n == (RAND_ITEMS - POOL_SIZE) / 2) drain_results();
    end

    // Let the last query finish, then allow a full walk's worth of cycles.
    in_tvalid <= 1'b0;
    waited = 0;
    while (board.pending_ranks.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (MAX_HOPS_DEF + 16) @(negedge clk);
    if (board.pending_ranks.size() != 0)
      board.report($sformatf("%0d rank beats never arrived", board.pending_ranks.size()));

    $display("covered %0d node writes and %0d lineage queries, %0d result beats checked",
             board.writes, board.queries, board.beats_checked);
    $display("%0d walks ran out of hops before reaching the root", board.truncated_walks);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
